// File: src/pulse_width_frame_transmitter_defines.svh
// Assertion macros used by the pulse width frame transmitter checker
`ifndef PULSE_WIDTH_FRAME_TRANSMITTER_DEFINES_SVH
`define PULSE_WIDTH_FRAME_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define PWFT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define PWFT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/pwft_pkg.sv
// Types and constants of the pulse width frame transmitter
`default_nettype none

package pwft_pkg;

   localparam int unsigned TICK_W  = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CNT_W   = 4;
   localparam int unsigned BITS_W  = 7;
   localparam int unsigned CSR_IDX_W = 3;

   // command codes carried on req_tuser
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_READY_TICKS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_TICKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_END_TICKS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_LINE = 3'd5;

   // register reset values
   localparam logic [TICK_W-1:0] RST_READY_TICKS = 8'd12;
   localparam logic [TICK_W-1:0] RST_START_TICKS = 8'd9;
   localparam logic [TICK_W-1:0] RST_ZERO_TICKS  = 8'd4;
   localparam logic [TICK_W-1:0] RST_ONE_TICKS   = 8'd6;
   localparam logic [TICK_W-1:0] RST_END_TICKS   = 8'd1;

   localparam logic [TICK_W-1:0] TICK_MAX      = 8'hFF;
   localparam logic [TICK_W-1:0] TICK_LINE_UP  = 8'd2;   // preamble / start rise
   localparam logic [TICK_W-1:0] TICK_BIT_UP   = 8'd1;   // data bit rise

   typedef enum logic [1:0] {
      PH_READY = 2'd0,
      PH_START = 2'd1,
      PH_BIT   = 2'd2,
      PH_END   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] ready_ticks;
      logic [TICK_W-1:0] start_ticks;
      logic [TICK_W-1:0] zero_ticks;
      logic [TICK_W-1:0] one_ticks;
      logic [TICK_W-1:0] end_ticks;
      logic              invert_line;
   } cfg_type;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      logic line_out;
      logic busy_res;
      logic frame_done;
      logic load_dropped;
   } result_type;

endpackage

`default_nettype wire

// File: src/pwft_csr.sv
// Configuration register file of the pulse width frame transmitter
`default_nettype none

module pwft_csr
   import pwft_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [CSR_IDX_W-1:0] wr_index,
   input  wire logic [TICK_W-1:0]    wr_data,
   output      cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_READY_TICKS: cfg_in.ready_ticks = wr_data;
            REG_START_TICKS: cfg_in.start_ticks = wr_data;
            REG_ZERO_TICKS:  cfg_in.zero_ticks  = wr_data;
            REG_ONE_TICKS:   cfg_in.one_ticks   = wr_data;
            REG_END_TICKS:   cfg_in.end_ticks   = wr_data;
            REG_INVERT_LINE: cfg_in.invert_line = wr_data[0];
            default: ;   // unmapped index, write ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_ticks <= RST_READY_TICKS;
         cfg_ff.start_ticks <= RST_START_TICKS;
         cfg_ff.zero_ticks  <= RST_ZERO_TICKS;
         cfg_ff.one_ticks   <= RST_ONE_TICKS;
         cfg_ff.end_ticks   <= RST_END_TICKS;
         cfg_ff.invert_line <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: src/pwft_core.sv
// Frame state, byte buffer and per-beat next-state logic
`default_nettype none

module pwft_core
   import pwft_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 8
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type result
);

   localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

   phase_type          phase_ff,      phase_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [TICK_W-1:0]  tick_mid;
   logic               running_ff,    running_in;
   logic               line_level_ff, line_level_in;
   logic [CNT_W-1:0]   load_count_ff, load_count_in;
   logic [BITS_W-1:0]  bits_sent_ff,  bits_sent_in;
   logic [BITS_W-1:0]  bits_total_ff, bits_total_in;
   logic [TICK_W-1:0]  bit_length_ff, bit_length_in;
   logic [BYTE_W-1:0]  frame_bytes_ff [MAX_BYTES];

   logic               store_en;
   logic [2:0]         rd_sel;
   logic [BYTE_W-1:0]  rd_byte;
   logic               next_bit;
   logic [TICK_W-1:0]  next_len;
   logic [TICK_W-1:0]  phase_len;
   logic               done;
   logic               dropped;

   // next data bit, MSB first
   assign rd_sel   = bits_sent_ff[5:3];
   assign rd_byte  = ({1'b0, rd_sel} < MAX_CNT) ? frame_bytes_ff[rd_sel[IDX_W-1:0]] : '0;
   assign next_bit = rd_byte[~bits_sent_ff[2:0]];
   assign next_len = next_bit ? cfg.one_ticks : cfg.zero_ticks;
   assign phase_len = (phase_ff == PH_READY) ? cfg.ready_ticks : cfg.start_ticks;

   always_comb begin
      phase_in      = phase_ff;
      tick_mid      = tick_count_ff;
      tick_count_in = tick_count_ff;
      running_in    = running_ff;
      line_level_in = line_level_ff;
      load_count_in = load_count_ff;
      bits_sent_in  = bits_sent_ff;
      bits_total_in = bits_total_ff;
      bit_length_in = bit_length_ff;
      store_en      = 1'b0;
      done          = 1'b0;
      dropped       = 1'b0;

      if (item.command == CMD_TICK) begin
         if (running_ff) begin
            case (phase_ff)
               PH_READY, PH_START: begin
                  if (tick_count_ff >= phase_len) begin
                     line_level_in = 1'b0;
                     tick_mid      = '0;
                     if (phase_ff == PH_READY) begin
                        phase_in = PH_START;
                     end else begin
                        phase_in      = PH_BIT;
                        bits_sent_in  = bits_sent_ff + 1'b1;
                        bit_length_in = next_len;
                     end
                  end else if (tick_count_ff == TICK_LINE_UP) begin
                     line_level_in = 1'b1;
                  end else if (tick_count_ff == '0) begin
                     line_level_in = 1'b0;
                  end
               end
               PH_BIT: begin
                  if (tick_count_ff >= bit_length_ff) begin
                     line_level_in = 1'b0;
                     tick_mid      = '0;
                     if (bits_sent_ff >= bits_total_ff) begin
                        phase_in = PH_END;
                     end else begin
                        bits_sent_in  = bits_sent_ff + 1'b1;
                        bit_length_in = next_len;
                     end
                  end else if (tick_count_ff == TICK_BIT_UP) begin
                     line_level_in = 1'b1;
                  end else if (tick_count_ff == '0) begin
                     line_level_in = 1'b0;
                  end
               end
               default: begin
                  if (tick_count_ff >= cfg.end_ticks) begin
                     phase_in      = PH_READY;
                     line_level_in = 1'b1;
                     tick_mid      = '0;
                     running_in    = 1'b0;
                     done          = 1'b1;
                  end
               end
            endcase
            tick_count_in = (tick_mid != TICK_MAX) ? tick_mid + 1'b1 : tick_mid;
         end
      end else if (running_ff) begin
         dropped = 1'b1;
      end else begin
         if (load_count_ff < MAX_CNT) begin
            store_en      = 1'b1;
            load_count_in = load_count_ff + 1'b1;
         end else begin
            dropped = 1'b1;
         end
         if (item.last_byte) begin
            bits_total_in = {load_count_in, 3'b000};
            bits_sent_in  = '0;
            phase_in      = PH_READY;
            tick_count_in = '0;
            running_in    = 1'b1;
            load_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_READY;
         tick_count_ff <= '0;
         running_ff    <= 1'b0;
         line_level_ff <= 1'b1;
         load_count_ff <= '0;
         bits_sent_ff  <= '0;
         bits_total_ff <= '0;
         bit_length_ff <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         running_ff    <= running_in;
         line_level_ff <= line_level_in;
         load_count_ff <= load_count_in;
         bits_sent_ff  <= bits_sent_in;
         bits_total_ff <= bits_total_in;
         bit_length_ff <= bit_length_in;
      end
   end

   // byte buffer, contents undefined until loaded
   always_ff @(posedge clock) begin
      if (step_en && store_en) begin
         frame_bytes_ff[load_count_ff[IDX_W-1:0]] <= item.byte_value;
      end
   end

   assign result.line_out     = line_level_in ^ cfg.invert_line;
   assign result.busy_res     = running_in;
   assign result.frame_done   = done;
   assign result.load_dropped = dropped;

endmodule

`default_nettype wire

// File: src/pulse_width_frame_transmitter.sv
// Top level of the pulse width frame transmitter
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata byte_value, tuser command, tlast last
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata line_out,busy_res; tlast frame_done;
//           |     |                        | tuser load_dropped
//   csr     | in  | csr_valid/csr_ready    | csr_index register, csr_wdata value
//
// One request beat per clock sustained while rsp_tready is high; each beat
// yields one response beat through the input register, then the result register.
// The request register and the result register form a two-stage pipe: a
// new beat is taken while a result waits, as long as the result moves on.
// Reset (synchronous, high) empties both stages, sets the line idle high
// and loads the register defaults; csr writes are always taken at once.
`default_nettype none

module pulse_width_frame_transmitter
   import pwft_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 8
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] byte_value
   input  wire logic                 req_tuser,   // [0] command
   input  wire logic                 req_tlast,   // last_byte
   // response channel
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [7:0]           rsp_tdata,   // [0] line_out, [1] busy_res, rest zero
   output      logic                 rsp_tuser,   // [0] load_dropped
   output      logic                 rsp_tlast,   // frame_done
   // configuration write channel
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_res_ff;
   result_type step_res;
   cfg_type    cfg;
   item_type   req_item;
   logic       advance;
   logic       req_take;

   // a held beat moves into the result register when that slot is free or its beat is taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign req_item.command    = req_tuser;
   assign req_item.byte_value = req_tdata;
   assign req_item.last_byte  = req_tlast;

   pwft_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   pwft_core #(
      .MAX_BYTES (MAX_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_res)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_res_ff.busy_res, out_res_ff.line_out};
   assign rsp_tuser  = out_res_ff.load_dropped;
   assign rsp_tlast  = out_res_ff.frame_done;

endmodule

`default_nettype wire

// File: src/pwft_checker.sv
// Port-level checks on the pulse width frame transmitter, bound to the top
`default_nettype none
`include "pulse_width_frame_transmitter_defines.svh"

module pwft_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   logic       rsp_stall;
   logic [9:0] rsp_beat;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat  = {rsp_tlast, rsp_tuser, rsp_tdata};

   // a stalled response beat holds
   `PWFT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_beat), "stalled beat changed")

   // a frame ends only on a tick, a drop only on a load
   `PWFT_ASSERT_NOW(a_done_drop, rsp_tvalid, !(rsp_tlast && rsp_tuser), "end and drop on one beat")

   // the end of a frame leaves the transmitter idle
   `PWFT_ASSERT_NOW(a_done_idle, rsp_tvalid && rsp_tlast, !rsp_tdata[1], "busy on frame end")

   // pipe is empty straight after reset
   `PWFT_ASSERT_NOW(a_rst_empty, $past(reset), !rsp_tvalid, "response beat straight after reset")

endmodule

bind pulse_width_frame_transmitter pwft_checker u_checker (.*);

`default_nettype wire
